>>> design/chacha_pkg.sv
//------------------------------------------------------------------------------
// chacha_pkg
// Shared types and constants for the ChaCha20 stream cipher controller and
// datapath.
//------------------------------------------------------------------------------
`default_nettype none

package chacha_pkg;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd7;

    localparam int POS_W = 6;   // byte position within a 64-byte block

    typedef enum logic [2:0] {
        ST_EMPTY,
        ST_HALF1,
        ST_HALF2,
        ST_ADD,
        ST_READY
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_HALF1,
        OP_HALF2,
        OP_ADD,
        OP_XOR
    } op_t;

    // Row rotation applied after the second half of a quarter round
    typedef enum logic [1:0] {
        PERM_SHIFT,
        PERM_SHIFT_DIAG,
        PERM_SHIFT_UNDIAG
    } perm_t;

    typedef struct packed {
        op_t              op;
        perm_t            perm;
        logic [POS_W-1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic cfg_hit;
    } status_t;

endpackage

`default_nettype wire

>>> design/chacha_dp.sv
//------------------------------------------------------------------------------
// chacha_dp
// Datapath: configuration registers, block counter, 16-word working state
// with a shared half quarter-round unit, and the byte XOR output register.
//------------------------------------------------------------------------------
`default_nettype none

module chacha_dp (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire chacha_pkg::cmd_t               cmd,
    output chacha_pkg::status_t                 status,
    input  wire  [7:0]                          s_tdata,
    input  wire                                 s_tlast,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [chacha_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast
);

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [1:0] row_rot(input chacha_pkg::perm_t p,
                                           input logic [1:0] r);
        unique case (p)
            chacha_pkg::PERM_SHIFT:        row_rot = 2'd1;
            chacha_pkg::PERM_SHIFT_DIAG:   row_rot = r + 2'd1;
            chacha_pkg::PERM_SHIFT_UNDIAG: row_rot = 2'd1 - r;
            default:                       row_rot = 2'd1;
        endcase
    endfunction

    logic [63:0] key_reg [4];
    logic [63:0] nonce01_reg;
    logic [31:0] nonce2_reg;
    logic [31:0] init_ctr_reg;
    logic [31:0] ctr_reg, ctr_next;

    logic [31:0] work_reg [16];
    logic [31:0] work_next [16];
    logic [31:0] init_w [16];
    logic [31:0] half_w [16];

    logic [31:0] qa, qb, qc, qd;
    logic [31:0] ta, tb, tc, td;
    logic [1:0]  col;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;
    logic        cfg_hit;

    assign cfg_ready      = 1'b1;
    assign cfg_hit        = cfg_valid && (cfg_index < chacha_pkg::CFG_COUNT);
    assign status.cfg_hit = cfg_hit;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
            nonce01_reg  <= '0;
            nonce2_reg   <= '0;
            init_ctr_reg <= '0;
        end else if (cfg_hit) begin
            unique case (cfg_index)
                chacha_pkg::CFG_KEY_01:   key_reg[0]   <= cfg_data;
                chacha_pkg::CFG_KEY_23:   key_reg[1]   <= cfg_data;
                chacha_pkg::CFG_KEY_45:   key_reg[2]   <= cfg_data;
                chacha_pkg::CFG_KEY_67:   key_reg[3]   <= cfg_data;
                chacha_pkg::CFG_NONCE_01: nonce01_reg  <= cfg_data;
                chacha_pkg::CFG_NONCE_2:  nonce2_reg   <= cfg_data[31:0];
                chacha_pkg::CFG_COUNTER:  init_ctr_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Block counter: a configuration write reloads it, a finished block advances it
    always_comb begin
        ctr_next = ctr_reg;
        if (cfg_hit) begin
            ctr_next = (cfg_index == chacha_pkg::CFG_COUNTER) ? cfg_data[31:0]
                                                               : init_ctr_reg;
        end else if (cmd.op == chacha_pkg::OP_ADD) begin
            ctr_next = ctr_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
        end else begin
            ctr_reg <= ctr_next;
        end
    end

    // Input state of the block function
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_w[i]         = chacha_pkg::SIGMA[i];
            init_w[4 + 2 * i] = key_reg[i][31:0];
            init_w[5 + 2 * i] = key_reg[i][63:32];
        end
        init_w[12] = ctr_reg;
        init_w[13] = nonce01_reg[31:0];
        init_w[14] = nonce01_reg[63:32];
        init_w[15] = nonce2_reg;
    end

    // Half quarter round on the fixed column at words 0, 4, 8 and 12
    always_comb begin
        qa = work_reg[0];
        qb = work_reg[4];
        qc = work_reg[8];
        qd = work_reg[12];
        if (cmd.op == chacha_pkg::OP_HALF1) begin
            ta = qa + qb;
            td = rotl(qd ^ ta, 16);
            tc = qc + td;
            tb = rotl(qb ^ tc, 12);
        end else begin
            ta = qa + qb;
            td = rotl(qd ^ ta, 8);
            tc = qc + td;
            tb = rotl(qb ^ tc, 7);
        end
        for (int i = 0; i < 16; i++) begin
            half_w[i] = work_reg[i];
        end
        half_w[0]  = ta;
        half_w[4]  = tb;
        half_w[8]  = tc;
        half_w[12] = td;
    end

    always_comb begin
        col = '0;
        for (int i = 0; i < 16; i++) begin
            work_next[i] = work_reg[i];
        end
        unique case (cmd.op)
            chacha_pkg::OP_LOAD: begin
                for (int i = 0; i < 16; i++) begin
                    work_next[i] = init_w[i];
                end
            end
            chacha_pkg::OP_HALF1: begin
                for (int i = 0; i < 16; i++) begin
                    work_next[i] = half_w[i];
                end
            end
            chacha_pkg::OP_HALF2: begin
                // rotate each row left so the next column or diagonal sits at column 0
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        col = 2'(c) + row_rot(cmd.perm, 2'(r));
                        work_next[r * 4 + c] = half_w[r * 4 + int'(col)];
                    end
                end
            end
            chacha_pkg::OP_ADD: begin
                for (int i = 0; i < 16; i++) begin
                    work_next[i] = work_reg[i] + init_w[i];
                end
            end
            chacha_pkg::OP_NONE, chacha_pkg::OP_XOR: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            work_reg[i] <= work_next[i];
        end
    end

    // Keystream byte: least significant byte of each word first
    assign ks_word = work_reg[cmd.pos[5:2]];
    assign ks_byte = ks_word[8 * cmd.pos[1:0] +: 8];

    always_ff @(posedge aclk) begin
        if (cmd.op == chacha_pkg::OP_XOR) begin
            m_tdata <= s_tdata ^ ks_byte;
            m_tlast <= s_tlast;
        end
    end

endmodule

`default_nettype wire

>>> design/chacha_ctrl.sv
//------------------------------------------------------------------------------
// chacha_ctrl
// Controller: sequences block generation over the shared quarter-round unit,
// tracks the byte position and the output register's valid flag.
//------------------------------------------------------------------------------
`default_nettype none

module chacha_ctrl #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    input  wire chacha_pkg::status_t  status,
    output chacha_pkg::cmd_t          cmd
);

    localparam int DR_W = $clog2(DOUBLE_ROUNDS);

    chacha_pkg::state_t             state_reg, state_next;
    logic [2:0]                     qr_reg, qr_next;
    logic [DR_W-1:0]                dr_reg, dr_next;
    logic [chacha_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           take;

    assign s_tready = (state_reg == chacha_pkg::ST_READY) && (!out_valid_reg || m_tready);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= chacha_pkg::ST_EMPTY;
            qr_reg        <= '0;
            dr_reg        <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            qr_reg        <= qr_next;
            dr_reg        <= dr_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        qr_next        = qr_reg;
        dr_next        = dr_reg;
        pos_next       = pos_reg;
        cmd.op         = chacha_pkg::OP_NONE;
        cmd.perm       = chacha_pkg::PERM_SHIFT;
        cmd.pos        = pos_reg;

        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        unique case (state_reg)
            chacha_pkg::ST_EMPTY: begin
                if (s_tvalid) begin
                    cmd.op     = chacha_pkg::OP_LOAD;
                    qr_next    = '0;
                    dr_next    = '0;
                    state_next = chacha_pkg::ST_HALF1;
                end
            end
            chacha_pkg::ST_HALF1: begin
                cmd.op     = chacha_pkg::OP_HALF1;
                state_next = chacha_pkg::ST_HALF2;
            end
            chacha_pkg::ST_HALF2: begin
                cmd.op = chacha_pkg::OP_HALF2;
                priority if (qr_reg == 3'd3) begin
                    cmd.perm = chacha_pkg::PERM_SHIFT_DIAG;
                end else if (qr_reg == 3'd7) begin
                    cmd.perm = chacha_pkg::PERM_SHIFT_UNDIAG;
                end else begin
                    cmd.perm = chacha_pkg::PERM_SHIFT;
                end
                qr_next    = qr_reg + 3'd1;
                state_next = chacha_pkg::ST_HALF1;
                if (qr_reg == 3'd7) begin
                    if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1)) begin
                        state_next = chacha_pkg::ST_ADD;
                    end else begin
                        dr_next = dr_reg + 1'b1;
                    end
                end
            end
            chacha_pkg::ST_ADD: begin
                cmd.op     = chacha_pkg::OP_ADD;
                pos_next   = '0;
                state_next = chacha_pkg::ST_READY;
            end
            chacha_pkg::ST_READY: begin
                if (take) begin
                    cmd.op   = chacha_pkg::OP_XOR;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == '1) begin
                        state_next = chacha_pkg::ST_EMPTY;
                    end
                end
            end
            default: begin
                state_next = chacha_pkg::ST_EMPTY;
            end
        endcase

        // any register write restarts the keystream
        if (status.cfg_hit) begin
            state_next = chacha_pkg::ST_EMPTY;
        end
    end

    a_out_from_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(take))
        else $error("output valid rose without an accepted transaction");

    a_load_starts_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chacha_pkg::ST_EMPTY && s_tvalid && !status.cfg_hit)
        |=> (state_reg == chacha_pkg::ST_HALF1 && qr_reg == 3'd0 && dr_reg == '0))
        else $error("block generation did not start from the first round");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        status.cfg_hit |=> (state_reg == chacha_pkg::ST_EMPTY))
        else $error("configuration write did not empty the keystream");

    a_fresh_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chacha_pkg::ST_ADD && !status.cfg_hit)
        |=> (state_reg == chacha_pkg::ST_READY && pos_reg == '0))
        else $error("new keystream block not started at byte zero");

endmodule

`default_nettype wire

>>> design/chacha20_stream_cipher.sv
// Timing: a byte is presented on m_ in the cycle after its transaction when the
//   keystream holds bytes; an empty keystream is first refilled by block generation
//   (load, rounds, add) on the shared half quarter-round unit.
// Throughput: one byte per cycle within a 64-byte block when the output is not
//   stalled; no byte is taken while the next block is being generated.
// Reset: synchronous, active low; registers and counter clear, keystream empty.
//------------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte stream cipher: XORs each input byte with the next keystream byte.
//------------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // tdata: data_byte[7:0]
    input  wire  [7:0]                          s_tdata,
    input  wire                                 s_tlast,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // tdata: result_byte[7:0]
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [chacha_pkg::CFG_DATA_W-1:0]   cfg_data
);

    chacha_pkg::cmd_t    cmd;
    chacha_pkg::status_t status;

    chacha_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chacha_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
